// ----- sv/tlba_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and search functions for the two-level bitmap
// index allocator. No dependencies; every other file of the block imports it.
package tlba_pkg;

    localparam int WORD_BITS   = 64;
    localparam int GROUP_WORDS = 4;
    localparam int NUM_WORDS   = 64;
    localparam int NUM_GROUPS  = (NUM_WORDS + GROUP_WORDS - 1) / GROUP_WORDS;
    localparam int CAPACITY    = NUM_WORDS * WORD_BITS;

    localparam int WORD_W  = $clog2(WORD_BITS);
    localparam int ADDR_W  = $clog2(NUM_WORDS);
    localparam int GRP_W   = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int INDEX_W = 12;
    localparam int LIMIT_W = 13;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 3;

    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_RESERVE = 2'd1;
    localparam logic [OP_W-1:0] OP_FREE    = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
    localparam logic [STAT_W-1:0] ST_NONE  = 3'd1;
    localparam logic [STAT_W-1:0] ST_BUSY  = 3'd2;
    localparam logic [STAT_W-1:0] ST_FREE  = 3'd3;
    localparam logic [STAT_W-1:0] ST_RANGE = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [INDEX_W-1:0] index;
    } t_req;

    typedef struct packed {
        logic [INDEX_W-1:0] result_index;
        logic [STAT_W-1:0]  status;
    } t_rsp;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_leaf_rd;

    typedef struct packed {
        logic                 en;
        logic [ADDR_W-1:0]    addr;
        logic [WORD_BITS-1:0] data;
    } t_leaf_wr;

    // Returns {found, position} of the lowest clear bit of a leaf word.
    function automatic logic [WORD_W:0] lowest_zero(input logic [WORD_BITS-1:0] w);
        logic [WORD_W:0] r;
        r = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (!w[b]) begin
                r = {1'b1, WORD_W'(b)};
            end
        end
        return r;
    endfunction

    // Returns {found, group} of the lowest group not marked full.
    function automatic logic [GRP_W:0] lowest_open_group(input logic [NUM_GROUPS-1:0] m);
        logic [GRP_W:0] r;
        r = '0;
        for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
            if (!m[g]) begin
                r = {1'b1, GRP_W'(g)};
            end
        end
        return r;
    endfunction

endpackage

// ----- sv/tlba_leaf_store.sv -----
`timescale 1ns / 1ps
// Leaf bitmap storage: one synchronous RAM of words with a registered read,
// plus a valid bit per word so that reset reads as all free. Uses tlba_pkg.
module tlba_leaf_store (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tlba_pkg::t_leaf_rd             i_rd,
    input  tlba_pkg::t_leaf_wr             i_wr,
    output logic [tlba_pkg::WORD_BITS-1:0] o_rd_word
);
    import tlba_pkg::*;

    logic [WORD_BITS-1:0] r_mem [NUM_WORDS];
    logic [NUM_WORDS-1:0] r_vld;
    logic [WORD_BITS-1:0] r_rd_data;
    logic                 r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
            r_rd_vld  <= r_vld[i_rd.addr];
        end
    end

    // A word never written since reset reads as all zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.addr] <= 1'b1;
        end
    end

    assign o_rd_word = r_rd_vld ? r_rd_data : '0;

endmodule

// ----- sv/two_level_bitmap_id_allocator_unit.sv -----
`timescale 1ns / 1ps
// Top level of the two-level bitmap index allocator.
// Depends on tlba_pkg and tlba_leaf_store.
//
// This block hands out unique indices from 0 to 4095. Each request carries an
// op: allocate returns the lowest free index below index_limit, reserve marks
// a named index busy, free releases a named index. Every request yields one
// response with an index and a status (ok, none free, already busy, already
// free, out of range). Requests are taken one at a time. An out-of-range or
// unknown request completes in the cycle it is accepted; reserve and free
// accept with a leaf RAM read and then do one read-modify-write of the word;
// allocate reads leaf words in turn, at most GROUP_WORDS per group that turns
// out full, since the single leaf RAM read
// port delivers one word per cycle. Groups already known full are skipped via
// the summary map at no cost. A new request is accepted in the cycle after the
// previous response is produced, and the response register lets that happen
// while the previous response is still waiting to be taken; only when that
// register is still occupied at completion does the block hold the new
// response and stall. Reset needs no clearing pass, since the leaf RAM uses
// per-word valid bits. index_limit may only be written while the block is
// idle; values above 4096 act as 4096.
module two_level_bitmap_id_allocator_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  tlba_pkg::t_req               i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output tlba_pkg::t_rsp               o_out_data,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [tlba_pkg::LIMIT_W-1:0] i_cfg_data
);
    import tlba_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_RMW  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]            r_state, n_state;
    logic [OP_W-1:0]       r_op, n_op;
    logic [INDEX_W-1:0]    r_index, n_index;
    logic [ADDR_W-1:0]     r_word, n_word;
    logic [NUM_GROUPS-1:0] r_group_full, n_group_full;
    logic [LIMIT_W-1:0]    r_limit;
    logic                  r_out_valid, n_out_valid;
    t_rsp                  r_out_data, n_out_data;
    t_rsp                  r_res, n_res;

    t_leaf_rd             w_rd;
    t_leaf_wr             w_wr;
    logic [WORD_BITS-1:0] w_rd_word;

    logic [LIMIT_W-1:0]    eff_limit;
    logic                  in_accept;
    logic                  out_free;
    logic                  emit;
    t_rsp                  emit_data;
    logic [GRP_W:0]        gsel;
    logic [WORD_W:0]       lz;
    logic [INDEX_W-1:0]    found_id;
    logic [GRP_W-1:0]      cur_group;
    logic [NUM_GROUPS-1:0] full_next;
    logic                  last_in_group;
    logic                  bit_busy;

    tlba_leaf_store u_leaf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd      (w_rd),
        .i_wr      (w_wr),
        .o_rd_word (w_rd_word)
    );

    assign eff_limit   = (r_limit > LIMIT_W'(CAPACITY)) ? LIMIT_W'(CAPACITY) : r_limit;
    assign in_accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_cfg_ready = 1'b1;

    // Scan helpers for the word currently returned by the leaf RAM.
    assign lz            = lowest_zero(w_rd_word);
    assign found_id      = {r_word, lz[WORD_W-1:0]};
    assign cur_group     = GRP_W'(r_word / GROUP_WORDS);
    assign last_in_group = ((r_word % GROUP_WORDS) == (GROUP_WORDS - 1)) ||
                           (r_word == ADDR_W'(NUM_WORDS - 1));
    assign bit_busy      = w_rd_word[r_index[WORD_W-1:0]];

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_index      = r_index;
        n_word       = r_word;
        n_group_full = r_group_full;
        n_res        = r_res;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_data   = r_out_data;
        w_rd         = '0;
        w_wr         = '0;
        emit         = 1'b0;
        emit_data    = '0;
        gsel         = '0;
        full_next    = r_group_full;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_op    = i_in_data.op;
                    n_index = i_in_data.index;
                    case (i_in_data.op)
                        OP_ALLOC: begin
                            gsel = lowest_open_group(r_group_full);
                            if (gsel[GRP_W]) begin
                                n_word    = ADDR_W'(gsel[GRP_W-1:0] * GROUP_WORDS);
                                w_rd.en   = 1'b1;
                                w_rd.addr = ADDR_W'(gsel[GRP_W-1:0] * GROUP_WORDS);
                                n_state   = S_SCAN;
                            end else begin
                                emit      = 1'b1;
                                emit_data = '{result_index: '0, status: ST_NONE};
                            end
                        end
                        OP_RESERVE, OP_FREE: begin
                            if ({1'b0, i_in_data.index} < eff_limit) begin
                                w_rd.en   = 1'b1;
                                w_rd.addr = i_in_data.index[INDEX_W-1:WORD_W];
                                n_state   = S_RMW;
                                // Free clears the group's full mark whatever the bit holds.
                                if (i_in_data.op == OP_FREE) begin
                                    n_group_full[GRP_W'(i_in_data.index[INDEX_W-1:WORD_W]
                                                        / GROUP_WORDS)] = 1'b0;
                                end
                            end else begin
                                emit      = 1'b1;
                                emit_data = '{result_index: i_in_data.index,
                                              status: ST_RANGE};
                            end
                        end
                        default: begin
                            emit      = 1'b1;
                            emit_data = '{result_index: i_in_data.index, status: ST_RANGE};
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (lz[WORD_W]) begin
                    // The first free bit decides: either it is handed out or nothing is.
                    emit = 1'b1;
                    if ({1'b0, found_id} < eff_limit) begin
                        w_wr.en   = 1'b1;
                        w_wr.addr = r_word;
                        w_wr.data = w_rd_word | (WORD_BITS'(1) << lz[WORD_W-1:0]);
                        emit_data = '{result_index: found_id, status: ST_OK};
                    end else begin
                        emit_data = '{result_index: '0, status: ST_NONE};
                    end
                end else if (last_in_group) begin
                    full_next            = r_group_full;
                    full_next[cur_group] = 1'b1;
                    n_group_full         = full_next;
                    gsel                 = lowest_open_group(full_next);
                    if (gsel[GRP_W]) begin
                        n_word    = ADDR_W'(gsel[GRP_W-1:0] * GROUP_WORDS);
                        w_rd.en   = 1'b1;
                        w_rd.addr = ADDR_W'(gsel[GRP_W-1:0] * GROUP_WORDS);
                    end else begin
                        emit      = 1'b1;
                        emit_data = '{result_index: '0, status: ST_NONE};
                    end
                end else begin
                    n_word    = r_word + ADDR_W'(1);
                    w_rd.en   = 1'b1;
                    w_rd.addr = r_word + ADDR_W'(1);
                end
            end
            S_RMW: begin
                emit = 1'b1;
                emit_data.result_index = r_index;
                w_wr.addr = r_index[INDEX_W-1:WORD_W];
                if (r_op == OP_RESERVE) begin
                    if (bit_busy) begin
                        emit_data.status = ST_BUSY;
                    end else begin
                        w_wr.en          = 1'b1;
                        w_wr.data        = w_rd_word |
                                           (WORD_BITS'(1) << r_index[WORD_W-1:0]);
                        emit_data.status = ST_OK;
                    end
                end else begin
                    if (bit_busy) begin
                        w_wr.en          = 1'b1;
                        w_wr.data        = w_rd_word &
                                           ~(WORD_BITS'(1) << r_index[WORD_W-1:0]);
                        emit_data.status = ST_OK;
                    end else begin
                        emit_data.status = ST_FREE;
                    end
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A finished response goes straight to the output register when it
        // is free, otherwise it is parked until the consumer takes the last one.
        if (emit) begin
            if (out_free) begin
                n_out_valid = 1'b1;
                n_out_data  = emit_data;
                n_state     = S_IDLE;
            end else begin
                n_res   = emit_data;
                n_state = S_FIN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_group_full <= '0;
            r_out_valid  <= 1'b0;
            r_limit      <= LIMIT_W'(4096);
        end else begin
            r_state      <= n_state;
            r_group_full <= n_group_full;
            r_out_valid  <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_index    <= n_index;
        r_word     <= n_word;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

    // The leaf RAM is only written while a word read in the previous cycle is
    // being modified.
    a_write_in_rmw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr.en |-> (r_state == S_SCAN || r_state == S_RMW))
        else $error("leaf write outside a read-modify-write state");

    // Reads and writes never meet in one cycle, so no forwarding is needed.
    a_no_rd_wr_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_wr.en && w_rd.en))
        else $error("leaf read and write in the same cycle");

    // A parked response exists only because the output register was occupied.
    a_fin_means_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |-> r_out_valid)
        else $error("response parked while output register empty");

    // An accepted request either completes at once or keeps the block busy.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state != S_IDLE) || r_out_valid)
        else $error("accepted request vanished");

    // Entering the scan always comes with a read of the first word to look at.
    a_scan_has_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && n_state == S_SCAN) |-> w_rd.en)
        else $error("scan entered without a leaf read");

endmodule
